// ----- rtl/lcdnw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Shared types, codes and constants of the character LCD nibble writer.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

    typedef enum logic [1:0] {
        OP_CMD  = 2'd0,
        OP_DATA = 2'd1,
        OP_INIT = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_POWERUP = 2'd0,
        CFG_PULSE   = 2'd1,
        CFG_GAP     = 2'd2,
        CFG_SETTLE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_POWERUP,
        BK_BYTE
    } t_back_state;

    typedef enum logic [1:0] {
        STEP_HI_EN     = 2'd0,
        STEP_HI_GAP    = 2'd1,
        STEP_LO_EN     = 2'd2,
        STEP_LO_SETTLE = 2'd3
    } t_step;

    localparam logic [7:0] RST_POWERUP = 8'd20;
    localparam logic [7:0] RST_PULSE   = 8'd2;
    localparam logic [7:0] RST_GAP     = 8'd2;
    localparam logic [7:0] RST_SETTLE  = 8'd5;

    localparam logic [2:0] LAST_INIT_IDX = 3'd4;

    typedef struct packed {
        logic       init;
        logic       rs;
        logic [7:0] byte_value;
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic       rs;
        logic       en;
        logic [3:0] nib;
        logic [7:0] hold;
        logic       last;
    } t_pin_state;

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] cmd;
        unique case (idx)
            3'd0:    cmd = 8'h02;
            3'd1:    cmd = 8'h28;
            3'd2:    cmd = 8'h0C;
            3'd3:    cmd = 8'h06;
            default: cmd = 8'h01;
        endcase
        return cmd;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/lcdnw_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnw_in_if
// Request channel: opcode and byte with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcdnw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] byte_value;

    modport source (output valid, output opcode, output byte_value, input ready);
    modport sink   (input valid, input opcode, input byte_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/lcdnw_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnw_out_if
// Pin state channel: LCD pin levels and hold time with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcdnw_out_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic       enable_pin;
    logic [3:0] bus_nibble;
    logic [7:0] hold_units;
    logic       last;

    modport source (output valid, output reg_select, output enable_pin, output bus_nibble,
                    output hold_units, output last, input ready);
    modport sink   (input valid, input reg_select, input enable_pin, input bus_nibble,
                    input hold_units, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/char_lcd_nibble_writer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// 4-bit character LCD writer: turns command, data and init requests into
// paced pin states.
// ----------------------------------------------------------------------------
// Each request is decoded by the front and queued (two entries); the back
// emits its pin states one at a time, and after presenting a state it waits
// until the hold-time counter has run down from hold_units units and the
// receiver can take a new state before presenting the next, so the stream of
// results follows real LCD timing. A byte write is four pin states paced by
// pulse, gap, pulse and settle units, and init is a powerup hold state followed
// by five byte writes. Requests are taken while the back is busy as long as
// the queue has room; opcode 3 is taken and dropped.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer #(
    parameter int CYCLES_PER_UNIT = 1000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    lcdnw_in_if.sink    i_in,
    lcdnw_out_if.source o_out
);

    lcdnw_pkg::t_q_stat q_stat;
    lcdnw_pkg::t_req    push_req;
    lcdnw_pkg::t_req    head_req;
    logic               push;
    logic               pop;

    lcdnw_front u_front (
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_req    (push_req)
    );

    lcdnw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .i_pop   (pop),
        .o_req   (head_req),
        .o_stat  (q_stat)
    );

    lcdnw_back #(
        .CYCLES_PER_UNIT (CYCLES_PER_UNIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_stat    (q_stat),
        .i_q_req     (head_req),
        .o_q_pop     (pop),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// ----- rtl/lcdnw_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnw_front
// Accepts requests, decodes the opcode and pushes real work into the queue.
// ----------------------------------------------------------------------------
module lcdnw_front (
    lcdnw_in_if.sink            i_in,
    input  lcdnw_pkg::t_q_stat  i_q_stat,
    output logic                o_push,
    output lcdnw_pkg::t_req     o_req
);

    lcdnw_pkg::t_opcode op;
    logic               keep;

    always_comb begin
        op         = lcdnw_pkg::t_opcode'(i_in.opcode);
        i_in.ready = !i_q_stat.full;
        o_req      = '0;
        keep       = 1'b0;
        unique case (op)
            lcdnw_pkg::OP_CMD: begin
                keep     = 1'b1;
            end
            lcdnw_pkg::OP_DATA: begin
                keep     = 1'b1;
                o_req.rs = 1'b1;
            end
            lcdnw_pkg::OP_INIT: begin
                keep       = 1'b1;
                o_req.init = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        o_req.byte_value = i_in.byte_value;
        o_push           = i_in.valid && i_in.ready && keep;
    end

endmodule
`default_nettype wire

// ----- rtl/lcdnw_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnw_fifo
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module lcdnw_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lcdnw_pkg::t_req     i_req,
    input  logic                i_pop,
    output lcdnw_pkg::t_req     o_req,
    output lcdnw_pkg::t_q_stat  o_stat
);

    lcdnw_pkg::t_req r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            n_wr_ptr;
    logic            n_rd_ptr;
    logic [1:0]      n_count;
    logic            do_push;
    logic            do_pop;

    always_comb begin
        o_stat.full  = (r_count == 2'd2);
        o_stat.empty = (r_count == 2'd0);
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        n_wr_ptr     = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr     = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_count      = r_count + {1'b0, do_push} - {1'b0, do_pop};
        o_req        = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lcdnw_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnw_back
// Sequences pin states for each queued request and paces them by hold time.
// ----------------------------------------------------------------------------
module lcdnw_back #(
    parameter int CYCLES_PER_UNIT = 1000
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_addr,
    input  logic [7:0]          i_cfg_wdata,
    input  lcdnw_pkg::t_q_stat  i_q_stat,
    input  lcdnw_pkg::t_req     i_q_req,
    output logic                o_q_pop,
    lcdnw_out_if.source         o_out
);

    localparam int UCW = (CYCLES_PER_UNIT > 1) ? $clog2(CYCLES_PER_UNIT) : 1;
    localparam logic [UCW-1:0] UNIT_MAX = UCW'(CYCLES_PER_UNIT - 1);

    logic [7:0] r_powerup;
    logic [7:0] r_pulse;
    logic [7:0] r_gap;
    logic [7:0] r_settle;

    lcdnw_pkg::t_back_state r_state, n_state;
    lcdnw_pkg::t_step       r_step, n_step;
    lcdnw_pkg::t_pin_state  r_out, n_out;
    logic                   r_out_valid, n_out_valid;
    logic                   r_init, n_init;
    logic                   r_rs, n_rs;
    logic [7:0]             r_byte, n_byte;
    logic [2:0]             r_idx, n_idx;
    logic [7:0]             r_hold_cnt, n_hold_cnt;
    logic [UCW-1:0]         r_unit_cnt, n_unit_cnt;

    logic                   can_emit;
    logic                   emit;
    logic                   byte_done;
    logic [7:0]             cur_byte;
    logic [3:0]             cur_nib;
    lcdnw_pkg::t_pin_state  pin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_powerup <= lcdnw_pkg::RST_POWERUP;
            r_pulse   <= lcdnw_pkg::RST_PULSE;
            r_gap     <= lcdnw_pkg::RST_GAP;
            r_settle  <= lcdnw_pkg::RST_SETTLE;
        end else if (i_cfg_we) begin
            unique case (lcdnw_pkg::t_cfg_idx'(i_cfg_addr))
                lcdnw_pkg::CFG_POWERUP: r_powerup <= i_cfg_wdata;
                lcdnw_pkg::CFG_PULSE:   r_pulse   <= i_cfg_wdata;
                lcdnw_pkg::CFG_GAP:     r_gap     <= i_cfg_wdata;
                lcdnw_pkg::CFG_SETTLE:  r_settle  <= i_cfg_wdata;
                default:                r_powerup <= r_powerup;
            endcase
        end
    end

    always_comb begin
        can_emit  = (r_hold_cnt == 8'd0) && (!r_out_valid || o_out.ready);
        cur_byte  = r_init ? lcdnw_pkg::init_cmd(r_idx) : r_byte;
        cur_nib   = (r_step == lcdnw_pkg::STEP_HI_EN || r_step == lcdnw_pkg::STEP_HI_GAP)
                    ? cur_byte[7:4] : cur_byte[3:0];
        byte_done = (r_step == lcdnw_pkg::STEP_LO_SETTLE)
                    && (!r_init || r_idx == lcdnw_pkg::LAST_INIT_IDX);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lcdnw_pkg::BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = i_q_req.init ? lcdnw_pkg::BK_POWERUP : lcdnw_pkg::BK_BYTE;
                end
            end
            lcdnw_pkg::BK_POWERUP: begin
                if (can_emit) begin
                    n_state = lcdnw_pkg::BK_BYTE;
                end
            end
            lcdnw_pkg::BK_BYTE: begin
                if (can_emit && byte_done) begin
                    n_state = lcdnw_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = lcdnw_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_q_pop = 1'b0;
        emit    = 1'b0;
        pin     = '0;
        n_init  = r_init;
        n_rs    = r_rs;
        n_byte  = r_byte;
        n_idx   = r_idx;
        n_step  = r_step;
        unique case (r_state)
            lcdnw_pkg::BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_q_pop = 1'b1;
                    n_init  = i_q_req.init;
                    n_rs    = i_q_req.rs;
                    n_byte  = i_q_req.byte_value;
                    n_idx   = 3'd0;
                    n_step  = lcdnw_pkg::STEP_HI_EN;
                end
            end
            lcdnw_pkg::BK_POWERUP: begin
                emit     = can_emit;
                pin.hold = r_powerup;
            end
            lcdnw_pkg::BK_BYTE: begin
                emit    = can_emit;
                pin.rs  = r_rs;
                pin.nib = cur_nib;
                unique case (r_step)
                    lcdnw_pkg::STEP_HI_EN: begin
                        pin.en   = 1'b1;
                        pin.hold = r_pulse;
                    end
                    lcdnw_pkg::STEP_HI_GAP: begin
                        pin.hold = r_gap;
                    end
                    lcdnw_pkg::STEP_LO_EN: begin
                        pin.en   = 1'b1;
                        pin.hold = r_pulse;
                    end
                    default: begin
                        pin.hold = r_settle;
                        pin.last = byte_done;
                    end
                endcase
                if (can_emit) begin
                    if (r_step == lcdnw_pkg::STEP_LO_SETTLE) begin
                        n_step = lcdnw_pkg::STEP_HI_EN;
                        n_idx  = r_idx + 3'd1;
                    end else begin
                        n_step = lcdnw_pkg::t_step'(r_step + 2'd1);
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out       = pin;
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        n_hold_cnt = r_hold_cnt;
        n_unit_cnt = r_unit_cnt;
        if (emit) begin
            n_hold_cnt = pin.hold;
            n_unit_cnt = UNIT_MAX;
        end else if (r_hold_cnt != 8'd0) begin
            if (r_unit_cnt == '0) begin
                n_hold_cnt = r_hold_cnt - 8'd1;
                n_unit_cnt = UNIT_MAX;
            end else begin
                n_unit_cnt = r_unit_cnt - UCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcdnw_pkg::BK_IDLE;
            r_step      <= lcdnw_pkg::STEP_HI_EN;
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
            r_hold_cnt  <= 8'd0;
            r_unit_cnt  <= '0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_hold_cnt  <= n_hold_cnt;
            r_unit_cnt  <= n_unit_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_init <= n_init;
        r_rs   <= n_rs;
        r_byte <= n_byte;
    end

    always_comb begin
        o_out.valid      = r_out_valid;
        o_out.reg_select = r_out.rs;
        o_out.enable_pin = r_out.en;
        o_out.bus_nibble = r_out.nib;
        o_out.hold_units = r_out.hold;
        o_out.last       = r_out.last;
    end

endmodule
`default_nettype wire

// ----- rtl/lcdnw_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnw_checker
// Port-level checks of the LCD nibble writer, bound to the top level.
// ----------------------------------------------------------------------------
module lcdnw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_reg_select,
    input logic       i_out_enable_pin,
    input logic [3:0] i_out_bus_nibble,
    input logic [7:0] i_out_hold_units,
    input logic       i_out_last
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_reg_select)
            && $stable(i_out_enable_pin) && $stable(i_out_bus_nibble)
            && $stable(i_out_hold_units) && $stable(i_out_last))
        else $error("pin state changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("pin state presented after reset");

    a_last_enable_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> !i_out_enable_pin)
        else $error("final pin state of a request with enable high");

    a_enable_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_enable_pin |=> !(i_out_valid && i_out_last
            && $past(i_out_enable_pin) && i_out_enable_pin))
        else $error("enable strobe not followed by a low interval");

endmodule

bind char_lcd_nibble_writer lcdnw_checker u_lcdnw_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_reg_select (o_out.reg_select),
    .i_out_enable_pin (o_out.enable_pin),
    .i_out_bus_nibble (o_out.bus_nibble),
    .i_out_hold_units (o_out.hold_units),
    .i_out_last       (o_out.last)
);
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Bench for the character LCD nibble writer. Command, data, init and unused
// requests go in over the request channel; every pin state that comes back
// is checked against a prediction built from the current timing registers.
// Runs a directed set at the reset timing and at the extreme timings, a long
// receiver hold-off that backs up the request queue, then random requests
// under several random timings, with sender and receiver stalling and then without stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int UNIT_CYCLES = 2;
    localparam int TAIL_CYCLES = 256 * UNIT_CYCLES + 32;
    localparam int MAX_REPORTS = 10;

    class pin_state_book;
        lcdnw_pkg::t_pin_state pending_pins[$];
        logic [7:0] timing[4];
        logic [7:0] boot_seq[5];
        int         mismatches;
        int         checked;
        int         op_count[4];

        function new();
            timing[lcdnw_pkg::CFG_POWERUP] = lcdnw_pkg::RST_POWERUP;
            timing[lcdnw_pkg::CFG_PULSE]   = lcdnw_pkg::RST_PULSE;
            timing[lcdnw_pkg::CFG_GAP]     = lcdnw_pkg::RST_GAP;
            timing[lcdnw_pkg::CFG_SETTLE]  = lcdnw_pkg::RST_SETTLE;
            boot_seq   = '{8'h02, 8'h28, 8'h0C, 8'h06, 8'h01};
            mismatches = 0;
            checked    = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        function void set_reg(lcdnw_pkg::t_cfg_idx idx, logic [7:0] value);
            timing[idx] = value;
        endfunction

        function int pending();
            return pending_pins.size();
        endfunction

        function void push_state(logic rs, logic en, logic [3:0] nib, logic [7:0] hold,
                                 logic fin);
            lcdnw_pkg::t_pin_state s;
            s.rs   = rs;
            s.en   = en;
            s.nib  = nib;
            s.hold = hold;
            s.last = fin;
            pending_pins.push_back(s);
        endfunction

        function void push_byte(logic rs, logic [7:0] b, logic fin);
            push_state(rs, 1'b1, b[7:4], timing[lcdnw_pkg::CFG_PULSE], 1'b0);
            push_state(rs, 1'b0, b[7:4], timing[lcdnw_pkg::CFG_GAP], 1'b0);
            push_state(rs, 1'b1, b[3:0], timing[lcdnw_pkg::CFG_PULSE], 1'b0);
            push_state(rs, 1'b0, b[3:0], timing[lcdnw_pkg::CFG_SETTLE], fin);
        endfunction

        function void note_request(lcdnw_pkg::t_opcode op, logic [7:0] b);
            op_count[op]++;
            case (op)
                lcdnw_pkg::OP_CMD:  push_byte(1'b0, b, 1'b1);
                lcdnw_pkg::OP_DATA: push_byte(1'b1, b, 1'b1);
                lcdnw_pkg::OP_INIT: begin
                    push_state(1'b0, 1'b0, 4'h0, timing[lcdnw_pkg::CFG_POWERUP], 1'b0);
                    for (int i = 0; i < 5; i++) push_byte(1'b0, boot_seq[i], i == 4);
                end
                default: ;
            endcase
        endfunction

        function void check_pin_state(lcdnw_pkg::t_pin_state got);
            lcdnw_pkg::t_pin_state want;
            checked++;
            if (pending_pins.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected pin state: rs=%0d en=%0d nib=%h hold=%0d last=%0d",
                             got.rs, got.en, got.nib, got.hold, got.last);
            end else begin
                want = pending_pins.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"pin state %0d: expected rs=%0d en=%0d nib=%h hold=%0d ",
                                  "last=%0d, got rs=%0d en=%0d nib=%h hold=%0d last=%0d"},
                                 checked, want.rs, want.en, want.nib, want.hold, want.last,
                                 got.rs, got.en, got.nib, got.hold, got.last);
                end
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       cfg_we;
    logic [1:0] cfg_addr;
    logic [7:0] cfg_wdata;

    lcdnw_in_if  req_if ();
    lcdnw_out_if pin_if ();

    pin_state_book book;
    int src_idle_pct;
    int sink_idle_pct;
    int stall_request;
    int stall_left;
    int timings_loaded;

    char_lcd_nibble_writer #(
        .CYCLES_PER_UNIT (UNIT_CYCLES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (req_if),
        .o_out       (pin_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #25_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        lcdnw_pkg::t_pin_state got;
        pin_if.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pin_if.valid && pin_if.ready) begin
                got.rs   = pin_if.reg_select;
                got.en   = pin_if.enable_pin;
                got.nib  = pin_if.bus_nibble;
                got.hold = pin_if.hold_units;
                got.last = pin_if.last;
                book.check_pin_state(got);
            end
            if (stall_request > 0) begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                pin_if.ready <= 1'b0;
            end else begin
                pin_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic send_request(lcdnw_pkg::t_opcode op, logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.opcode     <= op;
        req_if.byte_value <= b;
        do @(posedge i_clk); while (!req_if.ready);
        book.note_request(op, b);
    endtask

    task automatic stop_requests();
        req_if.valid <= 1'b0;
    endtask

    task automatic settle_block();
        stop_requests();
        while (book.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_timing(logic [7:0] pu, logic [7:0] pl, logic [7:0] gp,
                               logic [7:0] st);
        logic [7:0] vals[4];
        vals = '{pu, pl, gp, st};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= lcdnw_pkg::t_cfg_idx'(i);
            cfg_wdata <= vals[i];
            @(posedge i_clk);
            book.set_reg(lcdnw_pkg::t_cfg_idx'(i), vals[i]);
        end
        cfg_we <= 1'b0;
        timings_loaded++;
    endtask

    function automatic logic [7:0] pick_units();
        if ($urandom_range(15) == 0) return 8'($urandom_range(255));
        return 8'($urandom_range(9));
    endfunction

    task automatic send_random_item(output bit counted);
        int                 r;
        lcdnw_pkg::t_opcode op;
        r = $urandom_range(99);
        if (r < 15)      op = lcdnw_pkg::OP_INIT;
        else if (r < 50) op = lcdnw_pkg::OP_CMD;
        else if (r < 95) op = lcdnw_pkg::OP_DATA;
        else             op = lcdnw_pkg::OP_NONE;
        send_request(op, 8'($urandom_range(255)));
        counted = (op != lcdnw_pkg::OP_NONE);
    endtask

    initial begin
        bit counted;
        int n;
        book           = new();
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = lcdnw_pkg::CFG_POWERUP;
        cfg_wdata      = 8'h00;
        req_if.valid   = 1'b0;
        req_if.opcode  = lcdnw_pkg::OP_CMD;
        req_if.byte_value = 8'h00;
        src_idle_pct   = 28;
        sink_idle_pct  = 70;
        stall_request  = 0;
        timings_loaded = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset timing
        send_request(lcdnw_pkg::OP_CMD, 8'h00);
        send_request(lcdnw_pkg::OP_CMD, 8'hFF);
        send_request(lcdnw_pkg::OP_DATA, 8'h00);
        send_request(lcdnw_pkg::OP_DATA, 8'hFF);
        send_request(lcdnw_pkg::OP_NONE, 8'hFF);
        send_request(lcdnw_pkg::OP_DATA, 8'hA5);
        send_request(lcdnw_pkg::OP_INIT, 8'h00);
        send_request(lcdnw_pkg::OP_NONE, 8'h00);
        send_request(lcdnw_pkg::OP_CMD, 8'h5A);
        send_request(lcdnw_pkg::OP_INIT, 8'hFF);
        settle_block();

        // widest timing
        load_timing(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(lcdnw_pkg::OP_CMD, 8'hC3);
        send_request(lcdnw_pkg::OP_DATA, 8'h3C);
        send_request(lcdnw_pkg::OP_INIT, 8'h96);
        settle_block();

        // narrowest timing
        load_timing(8'h00, 8'h01, 8'h00, 8'h00);
        send_request(lcdnw_pkg::OP_DATA, 8'h69);
        send_request(lcdnw_pkg::OP_INIT, 8'h00);
        send_request(lcdnw_pkg::OP_CMD, 8'h81);
        settle_block();

        // zero enable pulse
        load_timing(8'hFF, 8'h00, 8'hFF, 8'h00);
        send_request(lcdnw_pkg::OP_INIT, 8'h7E);
        send_request(lcdnw_pkg::OP_CMD, 8'h18);
        send_request(lcdnw_pkg::OP_DATA, 8'hE7);
        settle_block();

        // hold the receiver off while requests keep coming
        load_timing(8'd3, 8'd2, 8'd1, 8'd3);
        src_idle_pct  = 0;
        stall_request = 400;
        for (int i = 0; i < 8; i++) send_request(lcdnw_pkg::OP_DATA, 8'($urandom_range(255)));
        settle_block();

        for (int seg = 0; seg < 3; seg++) begin
            case (seg)
                0: begin src_idle_pct = 28; sink_idle_pct = 70; end
                1: begin src_idle_pct = 70; sink_idle_pct = 28; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            for (int ph = 0; ph < 2; ph++) begin
                load_timing(pick_units(), pick_units(), pick_units(), pick_units());
                n = 0;
                while (n < 12) begin
                    send_random_item(counted);
                    if (counted) n++;
                end
                settle_block();
            end
        end

        $display("requests: %0d command, %0d data, %0d init, %0d unused opcode",
                 book.op_count[lcdnw_pkg::OP_CMD], book.op_count[lcdnw_pkg::OP_DATA],
                 book.op_count[lcdnw_pkg::OP_INIT], book.op_count[lcdnw_pkg::OP_NONE]);
        $display("pin states checked: %0d over %0d timing settings, mismatches: %0d",
                 book.checked, timings_loaded + 1, book.mismatches);
        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
